// ===== rtl/core/dnd_pkg.sv =====
// Shared types, constants and codes of the DNS name decompressor.
package dnd_pkg;

    // Packet store geometry.
    localparam int ADDR_W       = 12;
    localparam int PACKET_BYTES = 4096;
    localparam int POS_W        = ADDR_W + 1;

    // Name and label limits.
    localparam int MAX_NAME_BYTES = 255;
    localparam int NAME_LEN_W     = 8;
    localparam int LBL_W          = 6;
    localparam int OFF_W          = 14;

    // Output chunking.
    localparam int CHUNK_BYTES = 8;
    localparam int CNT_W       = 4;

    // Configuration registers.
    localparam int HDR_W      = 12;
    localparam int HOP_W      = 8;
    localparam int CFG_DATA_W = 12;
    localparam logic [HDR_W-1:0] HDR_RESET = HDR_W'(12);
    localparam logic [HOP_W-1:0] HOP_RESET = HOP_W'(16);

    // Special byte values.
    localparam logic [1:0] PTR_TAG  = 2'b11;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_HEADER_LEN = 1'b0;
    localparam t_cfg_index CFG_HOP_LIMIT  = 1'b1;

    typedef logic [0:0] t_func;
    localparam t_func FUNC_STORE  = 1'b0;
    localparam t_func FUNC_DECODE = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_HOPS  = 2'd2;
    localparam t_status ST_LONG  = 2'd3;

    typedef struct packed {
        t_func             func;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data_byte;
    } t_in_word;

    typedef struct packed {
        logic [8*CHUNK_BYTES-1:0] name_chunk;
        logic [CNT_W-1:0]         chunk_count;
        logic                     last;
        logic [ADDR_W-1:0]        next_index;
        t_status                  status;
    } t_out_word;

    // Command from the walker to the chunk builder.
    typedef struct packed {
        logic              put;
        logic              fin;
        logic [7:0]        ch;
        logic [ADDR_W-1:0] next;
        t_status           status;
    } t_chunk_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_TYPE,
        S_PTR,
        S_DOT,
        S_LREQ,
        S_LCHAR,
        S_FIN
    } t_state;

endpackage

// ===== rtl/core/dnd_store.sv =====
// Packet byte memory: one write port and one registered read port.
module dnd_store (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [dnd_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]                i_wr_data,
    input  logic [dnd_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                o_rd_data
);
    import dnd_pkg::*;

    logic [7:0] r_mem [PACKET_BYTES];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered, read every cycle.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/dnd_chunker.sv =====
// Chunk builder: packs name characters into 8-byte words and holds the output register.
module dnd_chunker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dnd_pkg::t_chunk_cmd i_cmd,
    output logic                o_cmd_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dnd_pkg::t_out_word  o_out_word
);
    import dnd_pkg::*;

    logic [8*CHUNK_BYTES-1:0] r_chunk, n_chunk;
    logic [CNT_W-1:0]         r_count, n_count;
    t_out_word                r_out, n_out;
    logic                     r_out_valid, n_out_valid;
    logic [8*CHUNK_BYTES-1:0] w_filled;

    // A command may emit a word, so it waits until the output register frees up.
    assign o_cmd_ready = !r_out_valid || i_out_ready;

    always_comb begin
        w_filled = r_chunk;
        for (int i = 0; i < CHUNK_BYTES; i++) begin
            if (r_count == CNT_W'(i)) begin
                w_filled[8*i +: 8] = i_cmd.ch;
            end
        end

        n_chunk     = r_chunk;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        priority if (i_cmd.fin) begin
            n_out.name_chunk  = r_chunk;
            n_out.chunk_count = r_count;
            n_out.last        = 1'b1;
            n_out.next_index  = i_cmd.next;
            n_out.status      = i_cmd.status;
            n_out_valid       = 1'b1;
            n_chunk           = '0;
            n_count           = '0;
        end else if (i_cmd.put) begin
            if (r_count == CNT_W'(CHUNK_BYTES - 1)) begin
                // Eighth character completes a full chunk.
                n_out.name_chunk  = w_filled;
                n_out.chunk_count = CNT_W'(CHUNK_BYTES);
                n_out.last        = 1'b0;
                n_out.next_index  = '0;
                n_out.status      = ST_OK;
                n_out_valid       = 1'b1;
                n_chunk           = '0;
                n_count           = '0;
            end else begin
                n_chunk = w_filled;
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            n_chunk = r_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_chunk     <= '0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_chunk     <= n_chunk;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== rtl/core/dnd_walker.sv =====
// Name walker: sequences store reads over labels and pointers and issues chunk commands.
module dnd_walker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  dnd_pkg::t_in_word          i_in_word,
    input  logic [dnd_pkg::HDR_W-1:0]  i_hdr_len,
    input  logic [dnd_pkg::HOP_W-1:0]  i_hop_limit,
    output logic                       o_wr_en,
    output logic [dnd_pkg::ADDR_W-1:0] o_wr_addr,
    output logic [7:0]                 o_wr_data,
    output logic [dnd_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output dnd_pkg::t_chunk_cmd        o_cmd,
    input  logic                       i_cmd_ready
);
    import dnd_pkg::*;

    t_state                r_state, n_state;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [LBL_W-1:0]      r_k, n_k;
    logic [LBL_W-1:0]      r_len, n_len;
    logic [LBL_W-1:0]      r_hi, n_hi;
    logic [HOP_W-1:0]      r_hops, n_hops;
    logic [ADDR_W-1:0]     r_next, n_next;
    logic [NAME_LEN_W-1:0] r_name_len, n_name_len;
    logic                  r_jumped, n_jumped;
    logic                  r_first, n_first;
    t_status               r_status, n_status;

    logic [POS_W-1:0] w_pos_1, w_pos_2, w_pos_k, w_pos_lbl;
    logic [OFF_W-1:0] w_off, w_rebased;
    logic             w_accept, w_full_name;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_pos_1     = r_pos + POS_W'(1);
    assign w_pos_2     = r_pos + POS_W'(2);
    assign w_pos_k     = r_pos + POS_W'(r_k);
    assign w_pos_lbl   = r_pos + POS_W'(r_len) + POS_W'(1);
    assign w_off       = {r_hi, i_rd_data};
    assign w_rebased   = w_off - OFF_W'(i_hdr_len);
    assign w_full_name = (r_name_len >= NAME_LEN_W'(MAX_NAME_BYTES));

    assign o_in_ready = (r_state == S_IDLE);

    // Byte loads go straight to the store.
    assign o_wr_en   = w_accept && (i_in_word.func == FUNC_STORE);
    assign o_wr_addr = i_in_word.address;
    assign o_wr_data = i_in_word.data_byte;

    // Read address follows the state, so a stalled character read repeats itself.
    always_comb begin
        unique case (r_state)
            S_TYPE:          o_rd_addr = w_pos_1[ADDR_W-1:0];
            S_LREQ, S_LCHAR: o_rd_addr = w_pos_k[ADDR_W-1:0];
            default:         o_rd_addr = r_pos[ADDR_W-1:0];
        endcase
    end

    // Next state and chunk commands.
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_k        = r_k;
        n_len      = r_len;
        n_hi       = r_hi;
        n_hops     = r_hops;
        n_next     = r_next;
        n_name_len = r_name_len;
        n_jumped   = r_jumped;
        n_first    = r_first;
        n_status   = r_status;
        o_cmd      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_word.func == FUNC_DECODE)) begin
                    n_pos      = POS_W'(i_in_word.address);
                    n_hops     = '0;
                    n_next     = '0;
                    n_name_len = '0;
                    n_jumped   = 1'b0;
                    n_first    = 1'b1;
                    n_status   = ST_OK;
                    n_state    = S_FETCH;
                end
            end

            S_FETCH: begin
                if (r_pos >= POS_W'(PACKET_BYTES)) begin
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_TYPE;
                end
            end

            S_TYPE: begin
                n_hi  = i_rd_data[LBL_W-1:0];
                n_len = i_rd_data[LBL_W-1:0];
                n_k   = LBL_W'(1);
                priority if (i_rd_data == 8'h00) begin
                    // End of name.
                    if (!r_jumped) begin
                        n_next = w_pos_1[ADDR_W-1:0];
                    end
                    n_state = S_FIN;
                end else if (i_rd_data[7:6] == PTR_TAG) begin
                    if (w_pos_1 >= POS_W'(PACKET_BYTES)) begin
                        n_status = ST_RANGE;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_PTR;
                    end
                end else if (i_rd_data[7:6] != 2'b00) begin
                    // Reserved label type.
                    n_status = ST_LONG;
                    n_state  = S_FIN;
                end else begin
                    n_first = 1'b0;
                    n_state = r_first ? S_LREQ : S_DOT;
                end
            end

            S_PTR: begin
                if (!r_jumped) begin
                    n_next   = w_pos_2[ADDR_W-1:0];
                    n_jumped = 1'b1;
                end
                priority if (r_hops >= i_hop_limit) begin
                    n_status = ST_HOPS;
                    n_state  = S_FIN;
                end else if ((w_off < OFF_W'(i_hdr_len)) ||
                             (w_rebased >= OFF_W'(PACKET_BYTES))) begin
                    n_hops   = r_hops + HOP_W'(1);
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else begin
                    n_hops  = r_hops + HOP_W'(1);
                    n_pos   = POS_W'(w_rebased);
                    n_state = S_FETCH;
                end
            end

            S_DOT: begin
                if (w_full_name) begin
                    n_status = ST_LONG;
                    n_state  = S_FIN;
                end else if (i_cmd_ready) begin
                    o_cmd.put  = 1'b1;
                    o_cmd.ch   = DOT_CHAR;
                    n_name_len = r_name_len + NAME_LEN_W'(1);
                    n_state    = S_LREQ;
                end
            end

            S_LREQ: begin
                if (w_pos_k >= POS_W'(PACKET_BYTES)) begin
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_LCHAR;
                end
            end

            S_LCHAR: begin
                if (w_full_name) begin
                    n_status = ST_LONG;
                    n_state  = S_FIN;
                end else if (i_cmd_ready) begin
                    o_cmd.put  = 1'b1;
                    o_cmd.ch   = i_rd_data;
                    n_name_len = r_name_len + NAME_LEN_W'(1);
                    if (r_k == r_len) begin
                        n_pos   = w_pos_lbl;
                        n_state = S_FETCH;
                    end else begin
                        n_k     = r_k + LBL_W'(1);
                        n_state = S_LREQ;
                    end
                end
            end

            S_FIN: begin
                if (i_cmd_ready) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.status = r_status;
                    o_cmd.next   = (r_status == ST_OK) ? r_next : '0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_len      <= n_len;
        r_hi       <= n_hi;
        r_hops     <= n_hops;
        r_next     <= n_next;
        r_name_len <= n_name_len;
        r_jumped   <= n_jumped;
        r_first    <= n_first;
        r_status   <= n_status;
    end

endmodule

// ===== rtl/core/dns_name_decompressor.sv =====
// DNS name decompressor: walks labels and compression pointers in a stored packet and
// returns the dotted name in 8-byte words. A decode runs through the single read port
// of the 4096-byte packet memory: each length byte and the closing zero are read in the
// fetch and type states, each compression pointer in the fetch, type and pointer states,
// each label character in the request and character states, each dot is sent from the
// dot state, and the last word is sent from the final state.
// A new word is accepted only after the last word of a decode has been handed to the
// output register; that register lets the next load or decode start while it waits.
// The packet memory has no reset and needs no clearing pass.
module dns_name_decompressor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dnd_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dnd_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  dnd_pkg::t_cfg_index           i_cfg_index,
    input  logic [dnd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dnd_pkg::*;

    logic [HDR_W-1:0]  r_hdr_len;
    logic [HOP_W-1:0]  r_hop_limit;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [7:0]        w_wr_data;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [7:0]        w_rd_data;
    t_chunk_cmd        w_cmd;
    logic              w_cmd_ready;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_len   <= HDR_RESET;
            r_hop_limit <= HOP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER_LEN: r_hdr_len   <= i_cfg_data[HDR_W-1:0];
                CFG_HOP_LIMIT:  r_hop_limit <= i_cfg_data[HOP_W-1:0];
                default:        r_hdr_len   <= r_hdr_len;
            endcase
        end
    end

    dnd_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    dnd_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_hdr_len   (r_hdr_len),
        .i_hop_limit (r_hop_limit),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    dnd_chunker u_chunker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== rtl/core/dnd_checker.sv =====
// Port-level checks of the DNS name decompressor and their bind to the top level.
module dnd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input dnd_pkg::t_out_word o_out_word
);
    import dnd_pkg::*;

    // A word that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // Every word before the last is a full, clean chunk.
    a_full_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |->
            o_out_word.chunk_count == CNT_W'(CHUNK_BYTES) &&
            o_out_word.status == ST_OK && o_out_word.next_index == '0)
        else $error("non-final chunk is not full or carries status");

    // The last word never holds a full chunk.
    a_last_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.last |->
            o_out_word.chunk_count < CNT_W'(CHUNK_BYTES))
        else $error("final chunk holds eight characters");

    // An error reports no next index.
    a_err_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.last && o_out_word.status != ST_OK |->
            o_out_word.next_index == '0)
        else $error("error word carries a next index");

endmodule

bind dns_name_decompressor dnd_checker u_dnd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ===== sim/testbench.sv =====
// Self-checking testbench of the DNS name decompressor with its own name walker.
module testbench;
    import dnd_pkg::*;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    // One row of the directed plan: an input word or a register write.
    typedef struct {
        t_row_kind             kind;
        t_func                 func;
        logic [ADDR_W-1:0]     addr;
        logic [CFG_DATA_W-1:0] data;
        t_cfg_index            reg_idx;
        bit                    typed;
        t_out_word             want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_word              in_word = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    t_cfg_index            cfg_index = CFG_HEADER_LEN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic                  o_cfg_ready;

    // Mirror of the packet store and of the two registers.
    logic [7:0]        pkt_mem   [PACKET_BYTES];
    bit                pkt_known [PACKET_BYTES];
    logic [HDR_W-1:0]  hdr_len = HDR_RESET;
    logic [HOP_W-1:0]  hop_lim = HOP_RESET;

    // Name walker scratch state and the words it produces.
    logic [63:0]       w_chunk;
    int unsigned       w_count;
    int unsigned       w_len;
    bit                walk_safe;
    t_out_word         walk_out [$];

    t_out_word         chunk_expect [$];
    logic [ADDR_W-1:0] name_starts [$];
    t_plan_row         plan [$];
    int unsigned       words_sent = 0;
    int unsigned       bad_words = 0;
    bit                feed_burst = 1'b0;
    bit                drain_burst = 1'b0;

    dns_name_decompressor dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Clock with a period of 8.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Reads one mirrored byte and notes whether it was ever written.
    function automatic logic [7:0] peek(input int unsigned p);
        if (!pkt_known[p]) begin
            walk_safe = 1'b0;
        end
        return pkt_known[p] ? pkt_mem[p] : 8'h00;
    endfunction

    function automatic void flush_chunk(input logic fin, input logic [ADDR_W-1:0] nxt,
                                        input t_status st);
        t_out_word w;
        w.name_chunk  = w_chunk;
        w.chunk_count = CNT_W'(w_count);
        w.last        = fin;
        w.next_index  = nxt;
        w.status      = st;
        walk_out.push_back(w);
        w_chunk = '0;
        w_count = 0;
    endfunction

    // Appends one character; a full chunk goes out at once.
    function automatic bit put_name_char(input logic [7:0] c);
        if (w_len >= MAX_NAME_BYTES) begin
            return 1'b0;
        end
        w_chunk[8*w_count +: 8] = c;
        w_count++;
        w_len++;
        if (w_count == CHUNK_BYTES) begin
            flush_chunk(1'b0, '0, ST_OK);
        end
        return 1'b1;
    endfunction

    // Walks the name at start and fills walk_out with the words it should give.
    // Returns 0 when the walk would read a byte that was never stored.
    function automatic bit walk_name(input logic [ADDR_W-1:0] start);
        int unsigned       pos;
        int unsigned       hops;
        int unsigned       off;
        int unsigned       k;
        logic [7:0]        b;
        logic [ADDR_W-1:0] nxt;
        t_status           st;
        bit                jumped;
        bit                first_lbl;
        bit                done;
        walk_out.delete();
        w_chunk   = '0;
        w_count   = 0;
        w_len     = 0;
        walk_safe = 1'b1;
        pos       = start;
        hops      = 0;
        nxt       = '0;
        st        = ST_OK;
        jumped    = 1'b0;
        first_lbl = 1'b1;
        done      = 1'b0;
        while (!done && st == ST_OK) begin
            if (pos >= PACKET_BYTES) begin
                st = ST_RANGE;
            end else begin
                b = peek(pos);
                if (b == 8'h00) begin
                    if (!jumped) begin
                        nxt = ADDR_W'(pos + 1);
                    end
                    done = 1'b1;
                end else if (b[7:6] == PTR_TAG) begin
                    if (pos + 1 >= PACKET_BYTES) begin
                        st = ST_RANGE;
                    end else begin
                        off = {18'd0, b[5:0], peek(pos + 1)};
                        if (!jumped) begin
                            nxt    = ADDR_W'(pos + 2);
                            jumped = 1'b1;
                        end
                        if (hops >= hop_lim) begin
                            st = ST_HOPS;
                        end else begin
                            hops++;
                            if (off < hdr_len || off - hdr_len >= PACKET_BYTES) begin
                                st = ST_RANGE;
                            end else begin
                                pos = off - hdr_len;
                            end
                        end
                    end
                end else if (b > 8'd63) begin
                    // Reserved label types.
                    st = ST_LONG;
                end else begin
                    if (!first_lbl && !put_name_char(DOT_CHAR)) begin
                        st = ST_LONG;
                    end
                    first_lbl = 1'b0;
                    for (k = 1; k <= b && st == ST_OK; k++) begin
                        if (pos + k >= PACKET_BYTES) begin
                            st = ST_RANGE;
                        end else if (!put_name_char(peek(pos + k))) begin
                            st = ST_LONG;
                        end
                    end
                    pos += b + 1;
                end
            end
        end
        flush_chunk(1'b1, (st == ST_OK) ? nxt : '0, st);
        return walk_safe;
    endfunction

    // Directed plan rows.
    function automatic void plan_put(input logic [ADDR_W-1:0] a, input logic [7:0] d);
        t_plan_row r;
        r = '{kind: ROW_WORD, func: FUNC_STORE, addr: a, data: CFG_DATA_W'(d),
              reg_idx: CFG_HEADER_LEN, typed: 1'b0, want: '0};
        plan.push_back(r);
    endfunction

    function automatic void plan_get(input logic [ADDR_W-1:0] a);
        t_plan_row r;
        r = '{kind: ROW_WORD, func: FUNC_DECODE, addr: a, data: '0,
              reg_idx: CFG_HEADER_LEN, typed: 1'b0, want: '0};
        plan.push_back(r);
    endfunction

    // Decode whose single empty last word is known by sight.
    function automatic void plan_want(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] nxt,
                                      input t_status st);
        t_plan_row r;
        r = '{kind: ROW_WORD, func: FUNC_DECODE, addr: a, data: '0,
              reg_idx: CFG_HEADER_LEN, typed: 1'b1, want: '0};
        r.want.last       = 1'b1;
        r.want.next_index = nxt;
        r.want.status     = st;
        plan.push_back(r);
    endfunction

    function automatic void plan_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] v);
        t_plan_row r;
        r = '{kind: ROW_REG, func: FUNC_STORE, addr: '0, data: v,
              reg_idx: idx, typed: 1'b0, want: '0};
        plan.push_back(r);
    endfunction

    // Offers one input word and updates the mirror when it is taken.
    task automatic send_word(input t_func f, input logic [ADDR_W-1:0] a, input logic [7:0] d,
                             input bit typed = 1'b0, input t_out_word want = '0);
        int unsigned gap;
        gap = feed_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{func: f, address: a, data_byte: d};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (f == FUNC_STORE) begin
            pkt_mem[a]   = d;
            pkt_known[a] = 1'b1;
        end else if (typed) begin
            chunk_expect.push_back(want);
        end else begin
            void'(walk_name(a));
            foreach (walk_out[i]) begin
                chunk_expect.push_back(walk_out[i]);
            end
        end
        words_sent++;
        if (words_sent % 40 == 0) begin
            feed_burst = ($urandom_range(0, 3) == 0);
        end
    endtask

    // Decodes only names whose walk stays on stored bytes.
    task automatic try_decode(input logic [ADDR_W-1:0] a);
        if (walk_name(a)) begin
            send_word(FUNC_DECODE, a, 8'($urandom_range(0, 255)));
        end
    endtask

    // Waits until the block has nothing left to deliver.
    task automatic settle();
        in_valid <= 1'b0;
        while (chunk_expect.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_HEADER_LEN) begin
            hdr_len = v[HDR_W-1:0];
        end else begin
            hop_lim = v[HOP_W-1:0];
        end
        cfg_valid <= 1'b0;
    endtask

    // Stores a name of random labels ending in a zero, a pointer or a broken byte,
    // then decodes it.
    task automatic build_name();
        logic [7:0]        name_bytes [$];
        logic [13:0]       ptr_off;
        int unsigned       base;
        int unsigned       len;
        int unsigned       pick;
        int unsigned       roll;
        base = ($urandom_range(0, 9) == 0) ? $urandom_range(4060, 4095)
                                           : $urandom_range(0, PACKET_BYTES - 1);
        repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(13, 63) : $urandom_range(1, 12);
            name_bytes.push_back(8'(len));
            repeat (len) name_bytes.push_back(8'($urandom_range(0, 255)));
        end
        roll = $urandom_range(0, 9);
        if (roll < 5) begin
            name_bytes.push_back(8'h00);
        end else if (roll < 9) begin
            if (roll == 8) begin
                // Offset below the header or far past the store.
                ptr_off = (hdr_len != 0 && $urandom_range(0, 1) == 1)
                        ? 14'($urandom_range(0, hdr_len - 1)) : 14'h3FFF;
            end else begin
                // Earlier name, or this very name for a loop.
                pick = $urandom_range(0, name_starts.size());
                ptr_off = (pick == name_starts.size()) ? 14'(base + hdr_len)
                                                       : 14'(name_starts[pick] + hdr_len);
            end
            name_bytes.push_back({PTR_TAG, ptr_off[13:8]});
            name_bytes.push_back(ptr_off[7:0]);
        end else begin
            name_bytes.push_back(8'($urandom_range(64, 191)));
        end
        foreach (name_bytes[i]) begin
            if (base + i < PACKET_BYTES) begin
                send_word(FUNC_STORE, ADDR_W'(base + i), name_bytes[i]);
            end
        end
        name_starts.push_back(ADDR_W'(base));
        if (name_starts.size() > 64) begin
            void'(name_starts.pop_front());
        end
        try_decode(ADDR_W'(base));
    endtask

    // Output side: random stalls, plus a long hold-off now and then to back up the input.
    initial begin : out_drain
        int unsigned hold;
        int unsigned taken;
        taken = 0;
        @(posedge i_clk);
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (taken % 150 == 40) begin
                hold = 300;
            end else begin
                hold = drain_burst ? 0 : $urandom_range(0, 7);
            end
            if (hold != 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
            if (taken % 32 == 0) begin
                drain_burst = ($urandom_range(0, 2) == 0);
            end
        end
    end

    // Compares every delivered word with the oldest expected one.
    always @(posedge i_clk) begin : chunk_check
        t_out_word want;
        if (rst_n && o_out_valid && out_ready) begin
            if (chunk_expect.size() == 0) begin
                bad_words++;
                if (bad_words <= 10) begin
                    $display("unexpected word: chunk %h count %0d last %0d next %0d status %0d",
                             o_out_word.name_chunk, o_out_word.chunk_count, o_out_word.last,
                             o_out_word.next_index, o_out_word.status);
                end
            end else begin
                want = chunk_expect.pop_front();
                if (o_out_word.name_chunk !== want.name_chunk ||
                    o_out_word.chunk_count !== want.chunk_count ||
                    o_out_word.last !== want.last ||
                    o_out_word.next_index !== want.next_index ||
                    o_out_word.status !== want.status) begin
                    bad_words++;
                    if (bad_words <= 10) begin
                        $display("word mismatch: want chunk %h count %0d last %0d next %0d st %0d",
                                 want.name_chunk, want.chunk_count, want.last,
                                 want.next_index, want.status);
                        $display("                got chunk %h count %0d last %0d next %0d st %0d",
                                 o_out_word.name_chunk, o_out_word.chunk_count, o_out_word.last,
                                 o_out_word.next_index, o_out_word.status);
                    end
                end
            end
        end
    end

    initial begin : run_limit
        #16000000;
        $display("[dns_name_decompressor] ERROR");
        $finish;
    end

    initial begin : stimulus
        int unsigned       ph;
        int unsigned       phase_from;
        int unsigned       roll;
        logic [HDR_W-1:0]  ph_hdr;
        logic [HOP_W-1:0]  ph_hop;

        // Root name, pointer cut off at the top of the store, both reserved label types.
        plan_put(12'd0, 8'h00);
        plan_want(12'd0, 12'd1, ST_OK);
        plan_put(12'd4095, 8'hC0);
        plan_want(12'd4095, 12'd0, ST_RANGE);
        plan_put(12'd1, 8'h40);
        plan_want(12'd1, 12'd0, ST_LONG);
        plan_put(12'd2, 8'hBF);
        plan_want(12'd2, 12'd0, ST_LONG);
        // Pointer straight to a zero byte gives the empty name.
        plan_put(12'd3, 8'hC0);
        plan_put(12'd4, 8'h0C);
        plan_want(12'd3, 12'd5, ST_OK);
        // Pointer offset inside the header.
        plan_put(12'd5, 8'hC0);
        plan_put(12'd6, 8'h0B);
        plan_want(12'd5, 12'd0, ST_RANGE);
        // Label of bytes 0xFF and 0x00 that points back to itself.
        plan_put(12'd7, 8'h02);
        plan_put(12'd8, 8'hFF);
        plan_put(12'd9, 8'h00);
        plan_put(12'd10, 8'hC0);
        plan_put(12'd11, 8'h13);
        plan_get(12'd7);
        // With many hops allowed the loop runs into the name length limit.
        plan_reg(CFG_HOP_LIMIT, 12'd255);
        plan_get(12'd7);
        plan_reg(CFG_HOP_LIMIT, 12'd1);
        plan_want(12'd3, 12'd5, ST_OK);
        plan_get(12'd7);
        plan_reg(CFG_HEADER_LEN, 12'd4095);
        plan_want(12'd3, 12'd0, ST_RANGE);
        // Label running past the end of the store.
        plan_put(12'd4094, 8'h05);
        plan_get(12'd4094);

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].data);
            end else begin
                send_word(plan[i].func, plan[i].addr, plan[i].data[7:0], plan[i].typed,
                          plan[i].want);
            end
        end

        // Random phases, each under its own register setting.
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    ph_hdr = HDR_RESET;
                    ph_hop = HOP_RESET;
                end
                1: begin
                    ph_hdr = '0;
                    ph_hop = 8'd255;
                end
                2: begin
                    ph_hdr = 12'd4095;
                    ph_hop = 8'd1;
                end
                default: begin
                    ph_hdr = HDR_W'($urandom_range(0, 4095));
                    ph_hop = HOP_W'($urandom_range(1, 255));
                end
            endcase
            settle();
            write_reg(CFG_HEADER_LEN, ph_hdr);
            settle();
            write_reg(CFG_HOP_LIMIT, {4'($urandom_range(0, 15)), ph_hop});
            phase_from = words_sent;
            while (words_sent - phase_from < 88) begin
                roll = $urandom_range(0, 9);
                if (roll < 7) begin
                    build_name();
                end else if (roll < 9) begin
                    if (name_starts.size() != 0 && $urandom_range(0, 3) != 0) begin
                        try_decode(name_starts[$urandom_range(0, name_starts.size() - 1)]);
                    end else begin
                        try_decode(ADDR_W'($urandom_range(0, PACKET_BYTES - 1)));
                    end
                end else begin
                    send_word(FUNC_STORE, ADDR_W'($urandom_range(0, PACKET_BYTES - 1)),
                              8'($urandom_range(0, 255)));
                end
            end
        end

        in_valid <= 1'b0;
        while (chunk_expect.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (bad_words == 0) begin
            $display("[dns_name_decompressor] OK");
        end else begin
            $display("[dns_name_decompressor] ERROR");
        end
        $finish;
    end
endmodule
